FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL of the scheduler.
// Users must have clk and rst_n (synchronous, active low) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/msq_pkg.sv
// Types and codes of the multilevel queue slot scheduler.
// No dependencies; used by the channel interfaces, the top level, the checker and the bench.
package msq_pkg;

  localparam int PROC_W   = 8;
  localparam int LEVEL_W  = 3;
  localparam int STATUS_W = 2;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DROP  = 2'd2
  } status_t;

  typedef struct packed {
    status_t              status;
    logic                 got_proc;
    logic [PROC_W-1:0]    out_proc_id;
    logic [LEVEL_W-1:0]   out_level;
  } result_t;

endpackage

FILE: rtl/msq_chan_if.sv
// Valid/ready channel interfaces of the scheduler: request in, result out.
// Depends on msq_pkg.
interface msq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [msq_pkg::PROC_W-1:0]    proc_id;
  logic [msq_pkg::LEVEL_W-1:0]   level;

  modport source (output valid, req_type, proc_id, level, input ready);
  modport sink   (input valid, req_type, proc_id, level, output ready);
endinterface

interface msq_out_if;
  logic                          valid;
  logic                          ready;
  msq_pkg::status_t              status;
  logic                          got_proc;
  logic [msq_pkg::PROC_W-1:0]    out_proc_id;
  logic [msq_pkg::LEVEL_W-1:0]   out_level;

  modport source (output valid, status, got_proc, out_proc_id, out_level, input ready);
  modport sink   (input valid, status, got_proc, out_proc_id, out_level, output ready);
endinterface

FILE: rtl/multilevel_queue_slot_scheduler.sv
// Multilevel queue slot scheduler: per-level FIFOs in one handle memory, per-level
// head/fill/budget in a level memory. Depends on msq_pkg, msq_chan_if, assert_macros.svh.
// Enqueue: level memory read, then write. Dequeue: level memory read, handle memory read,
// then result. Empty dequeue and out-of-range enqueue answer straight from idle.
// One request in flight; the next is taken once the result is in the output register.
// Reset: synchronous; per-level valid and flag bits clear at once, no memory sweep.
`include "assert_macros.svh"

module multilevel_queue_slot_scheduler #(
  parameter int LEVELS      = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  msq_in_if.sink       in_chan,
  msq_out_if.source    out_chan
);

  localparam int LW       = $clog2(LEVELS);
  localparam int SW       = $clog2(QUEUE_DEPTH);
  localparam int CW       = $clog2(QUEUE_DEPTH + 1);
  localparam int BW       = $clog2(LEVELS + 1);
  localparam int TW       = CW + 1;
  localparam int EW       = SW + CW + BW;
  localparam int HS_DEPTH = 1 << (LW + SW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_DEQ_RD,
    S_DEQ_OUT,
    S_HOLD
  } state_t;

  state_t                 state_r, state_nxt;
  logic [LW-1:0]          sel_r, sel_nxt;
  logic [HANDLE_BITS-1:0] pid_r, pid_nxt;
  logic [LEVELS-1:0]      nonempty_r, nonempty_nxt;
  logic [LEVELS-1:0]      bok_r, bok_nxt;
  logic [LEVELS-1:0]      stale_r, stale_nxt;
  logic [LEVELS-1:0]      lv_r, lv_nxt;
  logic                   out_valid_r, out_valid_nxt;
  msq_pkg::result_t       out_res_r, out_res_nxt;
  msq_pkg::result_t       res_r, res_nxt;
  msq_pkg::result_t       done_res;
  logic                   done;

  // level memory: {head, fill, budget}
  logic [EW-1:0]          lm_mem [LEVELS];
  logic [EW-1:0]          lm_rdata_r;
  logic                   lm_re, lm_we;
  logic [LW-1:0]          lm_raddr, lm_waddr;
  logic [EW-1:0]          lm_wdata;

  // handle memory: {level, slot}
  logic [HANDLE_BITS-1:0] hs_mem [HS_DEPTH];
  logic [HANDLE_BITS-1:0] hs_rdata_r;
  logic                   hs_re, hs_we;
  logic [LW+SW-1:0]       hs_raddr, hs_waddr;

  logic                   out_free;
  logic                   lvl_ok;
  logic [LW-1:0]          lvl_idx;
  logic [LEVELS-1:0]      cand;
  logic [LW-1:0]          first_ne, first_cand;
  logic [SW-1:0]          head, head_inc, tail;
  logic [CW-1:0]          fill, fill_dec;
  logic [BW-1:0]          bud_raw, bud_cur, bud_dec, refill_val;
  logic [TW-1:0]          tail_sum;

  always_ff @(posedge clk) begin
    if (lm_we) begin
      lm_mem[lm_waddr] <= lm_wdata;
    end
    if (lm_re) begin
      lm_rdata_r <= lm_mem[lm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (hs_we) begin
      hs_mem[hs_waddr] <= pid_r;
    end
    if (hs_re) begin
      hs_rdata_r <= hs_mem[hs_raddr];
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;
  assign lvl_ok   = 32'(in_chan.level) < 32'(LEVELS);
  assign lvl_idx  = LW'(in_chan.level);
  assign cand     = nonempty_r & bok_r;

  always_comb begin
    first_ne   = '0;
    first_cand = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_r[i]) begin
        first_ne = LW'(i);
      end
      if (cand[i]) begin
        first_cand = LW'(i);
      end
    end
  end

  // entry never written reads as head 0, fill 0
  assign head       = lv_r[sel_r] ? lm_rdata_r[EW-1 -: SW] : '0;
  assign fill       = lv_r[sel_r] ? lm_rdata_r[BW +: CW] : '0;
  assign bud_raw    = lm_rdata_r[BW-1:0];
  assign refill_val = BW'(LEVELS) - BW'(sel_r);
  assign bud_cur    = stale_r[sel_r] ? refill_val : bud_raw;
  assign bud_dec    = bud_cur - BW'(1);
  assign fill_dec   = fill - CW'(1);
  assign head_inc   = (head == SW'(QUEUE_DEPTH - 1)) ? '0 : head + SW'(1);
  assign tail_sum   = TW'(head) + TW'(fill);
  assign tail       = (tail_sum >= TW'(QUEUE_DEPTH)) ? SW'(tail_sum - TW'(QUEUE_DEPTH))
                                                     : SW'(tail_sum);

  assign in_chan.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    sel_nxt      = sel_r;
    pid_nxt      = pid_r;
    nonempty_nxt = nonempty_r;
    bok_nxt      = bok_r;
    stale_nxt    = stale_r;
    lv_nxt       = lv_r;
    res_nxt      = res_r;
    out_res_nxt  = out_res_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    done         = 1'b0;
    done_res     = '{status: msq_pkg::ST_OK, got_proc: 1'b0, out_proc_id: '0, out_level: '0};
    lm_re        = 1'b0;
    lm_raddr     = sel_r;
    lm_we        = 1'b0;
    lm_waddr     = sel_r;
    lm_wdata     = {head, fill, bud_raw};
    hs_re        = 1'b0;
    hs_raddr     = {sel_r, head};
    hs_we        = 1'b0;
    hs_waddr     = {sel_r, tail};

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          if (in_chan.req_type == msq_pkg::REQ_ENQ) begin
            pid_nxt = HANDLE_BITS'(in_chan.proc_id);
            if (lvl_ok) begin
              sel_nxt   = lvl_idx;
              lm_re     = 1'b1;
              lm_raddr  = lvl_idx;
              state_nxt = S_ENQ;
            end else begin
              done            = 1'b1;
              done_res.status = msq_pkg::ST_DROP;
            end
          end else if (nonempty_r == '0) begin
            done            = 1'b1;
            done_res.status = msq_pkg::ST_EMPTY;
          end else if (cand == '0) begin
            // all budgets spent: refill every level, take the first busy one
            stale_nxt = '1;
            bok_nxt   = '1;
            sel_nxt   = first_ne;
            lm_re     = 1'b1;
            lm_raddr  = first_ne;
            state_nxt = S_DEQ_RD;
          end else begin
            sel_nxt   = first_cand;
            lm_re     = 1'b1;
            lm_raddr  = first_cand;
            state_nxt = S_DEQ_RD;
          end
        end
      end
      S_ENQ: begin
        done = 1'b1;
        if (fill >= CW'(QUEUE_DEPTH)) begin
          done_res.status = msq_pkg::ST_DROP;
        end else begin
          hs_we               = 1'b1;
          lm_we               = 1'b1;
          lm_wdata            = {head, fill + CW'(1), bud_raw};
          nonempty_nxt[sel_r] = 1'b1;
          lv_nxt[sel_r]       = 1'b1;
        end
      end
      S_DEQ_RD: begin
        hs_re               = 1'b1;
        lm_we               = 1'b1;
        lm_wdata            = {head_inc, fill_dec, bud_dec};
        stale_nxt[sel_r]    = 1'b0;
        bok_nxt[sel_r]      = (bud_dec != '0);
        nonempty_nxt[sel_r] = (fill_dec != '0);
        lv_nxt[sel_r]       = 1'b1;
        state_nxt           = S_DEQ_OUT;
      end
      S_DEQ_OUT: begin
        done                 = 1'b1;
        done_res.got_proc    = 1'b1;
        done_res.out_proc_id = msq_pkg::PROC_W'(hs_rdata_r);
        done_res.out_level   = msq_pkg::LEVEL_W'(sel_r);
      end
      S_HOLD: begin
        if (out_free) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      if (out_free) begin
        out_res_nxt   = done_res;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end else begin
        res_nxt   = done_res;
        state_nxt = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    sel_r     <= sel_nxt;
    pid_r     <= pid_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nonempty_r  <= '0;
      bok_r       <= '0;
      stale_r     <= '0;
      lv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nonempty_r  <= nonempty_nxt;
      bok_r       <= bok_nxt;
      stale_r     <= stale_nxt;
      lv_r        <= lv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_res_r.status;
  assign out_chan.got_proc    = out_res_r.got_proc;
  assign out_chan.out_proc_id = out_res_r.out_proc_id;
  assign out_chan.out_level   = out_res_r.out_level;

  `ASSERT_IMPLIES(a_sel_has_entries, state_r == S_DEQ_RD, nonempty_r[sel_r], "dequeue picked an empty level")
  `ASSERT_IMPLIES(a_sel_has_budget, state_r == S_DEQ_RD, bok_r[sel_r], "dequeue picked a level without budget")
  `ASSERT_ALWAYS(a_budget_backed, (bok_r & ~lv_r & ~stale_r) == '0, "budget flag without stored budget")
  `ASSERT_IMPLIES(a_hold_blocked, state_r == S_HOLD, out_valid_r, "result held while output is free")

endmodule

FILE: bench/msq_result_checker.sv
// Checker for the multilevel queue slot scheduler: watches both channels, predicts each
// result from its own copy of the FIFOs and slot budgets, and compares field by field.
// Depends on msq_pkg.
module msq_result_checker #(
  parameter int LEVELS      = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [msq_pkg::PROC_W-1:0]  in_proc_id,
  input  logic [msq_pkg::LEVEL_W-1:0] in_level,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  msq_pkg::status_t            out_status,
  input  logic                        out_got_proc,
  input  logic [msq_pkg::PROC_W-1:0]  out_proc_id,
  input  logic [msq_pkg::LEVEL_W-1:0] out_level,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [msq_pkg::PROC_W-1:0] slots [LEVELS][QUEUE_DEPTH];
  int                         head   [LEVELS];
  int                         fill   [LEVELS];
  int                         budget [LEVELS];
  msq_pkg::result_t           pending_results [$];

  function automatic int pick_level();
    for (int i = 0; i < LEVELS; i++) begin
      if (fill[i] > 0 && budget[i] > 0) return i;
    end
    return -1;
  endfunction

  function automatic msq_pkg::result_t schedule_step(logic req,
                                                     logic [msq_pkg::PROC_W-1:0] pid,
                                                     logic [msq_pkg::LEVEL_W-1:0] lvl);
    msq_pkg::result_t           r;
    int                         sel;
    bit                         busy;
    logic [msq_pkg::PROC_W-1:0] keep_mask;
    keep_mask = msq_pkg::PROC_W'((64'd1 << HANDLE_BITS) - 64'd1);
    r = '0;
    r.status = msq_pkg::ST_OK;
    if (req == msq_pkg::REQ_ENQ) begin
      if (int'(lvl) >= LEVELS || fill[lvl] >= QUEUE_DEPTH) begin
        r.status = msq_pkg::ST_DROP;
      end else begin
        slots[lvl][(head[lvl] + fill[lvl]) % QUEUE_DEPTH] = pid & keep_mask;
        fill[lvl]++;
      end
    end else begin
      busy = 1'b0;
      for (int i = 0; i < LEVELS; i++) busy |= (fill[i] > 0);
      if (!busy) begin
        r.status = msq_pkg::ST_EMPTY;
      end else begin
        sel = pick_level();
        if (sel < 0) begin
          for (int i = 0; i < LEVELS; i++) budget[i] = LEVELS - i;
          sel = pick_level();
        end
        r.got_proc    = 1'b1;
        r.out_proc_id = slots[sel][head[sel]];
        r.out_level   = sel[msq_pkg::LEVEL_W-1:0];
        head[sel]     = (head[sel] + 1) % QUEUE_DEPTH;
        fill[sel]--;
        budget[sel]--;
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] seen);
    if (mismatches < 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, seen);
    mismatches++;
  endtask

  always @(posedge clk) begin
    msq_pkg::result_t want;
    msq_pkg::result_t seen;
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i]   = 0;
        fill[i]   = 0;
        budget[i] = 0;
      end
      pending_results.delete();
    end else begin
      if (in_valid && in_ready)
        pending_results.push_back(schedule_step(in_req_type, in_proc_id, in_level));
      if (out_valid && out_ready) begin
        seen.status      = out_status;
        seen.got_proc    = out_got_proc;
        seen.out_proc_id = out_proc_id;
        seen.out_level   = out_level;
        if (pending_results.size() == 0) begin
          report("unexpected transfer", '0, 32'(seen));
        end else begin
          want = pending_results.pop_front();
          if (seen.status !== want.status)
            report("status", 32'(want.status), 32'(seen.status));
          if (seen.got_proc !== want.got_proc)
            report("got_proc", 32'(want.got_proc), 32'(seen.got_proc));
          if (seen.out_proc_id !== want.out_proc_id)
            report("out_proc_id", 32'(want.out_proc_id), 32'(seen.out_proc_id));
          if (seen.out_level !== want.out_level)
            report("out_level", 32'(want.out_level), 32'(seen.out_level));
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

FILE: bench/tb_top.sv
// Top of the scheduler bench: clock, reset, request stimulus and result back-pressure.
// Depends on msq_pkg, msq_chan_if, the scheduler RTL and msq_result_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS      = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 8;

  logic clk;
  logic rst_n = 1'b0;
  int   mismatches;
  int   outstanding;
  bit   in_burst;

  msq_in_if  in_chan ();
  msq_out_if out_chan ();

  multilevel_queue_slot_scheduler #(
    .LEVELS     (LEVELS),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  msq_result_checker #(
    .LEVELS     (LEVELS),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_req_type (in_chan.req_type),
    .in_proc_id  (in_chan.proc_id),
    .in_level    (in_chan.level),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_status  (out_chan.status),
    .out_got_proc(out_chan.got_proc),
    .out_proc_id (out_chan.out_proc_id),
    .out_level   (out_chan.out_level),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // valid stays high across back-to-back transfers
  task automatic send_req(logic req, logic [msq_pkg::PROC_W-1:0] pid,
                          logic [msq_pkg::LEVEL_W-1:0] lvl);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.req_type <= req;
    in_chan.proc_id  <= pid;
    in_chan.level    <= lvl;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  initial begin
    int  enq_pct;
    int  hot;
    bit  narrow;
    logic req;
    in_chan.valid    = 1'b0;
    in_chan.req_type = msq_pkg::REQ_ENQ;
    in_chan.proc_id  = '0;
    in_chan.level    = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty dequeue, extremes, refill on first dequeue, full level drop
    in_burst = 1'b0;
    send_req(msq_pkg::REQ_DEQ, 8'hFF, 3'd7);
    send_req(msq_pkg::REQ_ENQ, 8'hFF, 3'd7);
    send_req(msq_pkg::REQ_ENQ, 8'h00, 3'd0);
    send_req(msq_pkg::REQ_DEQ, 8'h00, 3'd0);
    send_req(msq_pkg::REQ_DEQ, 8'hA5, 3'd5);
    send_req(msq_pkg::REQ_DEQ, 8'h5A, 3'd2);
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      send_req(msq_pkg::REQ_ENQ, msq_pkg::PROC_W'($urandom_range(0, 255)), 3'd5);

    for (int phase = 0; phase < 18; phase++) begin
      in_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0: enq_pct = 20;
        1: enq_pct = 45;
        2: enq_pct = 55;
        3: enq_pct = 70;
        default: enq_pct = 90;
      endcase
      hot    = $urandom_range(0, LEVELS - 1);
      narrow = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < 100; k++) begin
        req = ($urandom_range(0, 99) < enq_pct) ? msq_pkg::REQ_ENQ : msq_pkg::REQ_DEQ;
        send_req(req, msq_pkg::PROC_W'($urandom_range(0, 255)),
                 narrow ? msq_pkg::LEVEL_W'(hot ^ $urandom_range(0, 1))
                        : msq_pkg::LEVEL_W'($urandom_range(0, LEVELS - 1)));
      end
    end
    in_chan.valid <= 1'b0;

    // let the count from the last transfer settle first
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("[multilevel_queue_slot_scheduler] OK");
    else
      $display("[multilevel_queue_slot_scheduler] ERROR");
    $finish;
  end

  initial begin
    int  n;
    int  gap;
    bit  burst;
    n = 0;
    burst = 1'b0;
    out_chan.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      n++;
    end
  end

  initial begin
    #3_000_000;
    $display("[multilevel_queue_slot_scheduler] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/msq_pkg.sv
rtl/msq_chan_if.sv
rtl/multilevel_queue_slot_scheduler.sv
bench/msq_result_checker.sv
bench/tb_top.sv
